[hw/rtl/byte_run_length_encoder_assert.svh]
// Assertion helpers for the run-length encoder.
`ifndef BYTE_RUN_LENGTH_ENCODER_ASSERT_SVH
`define BYTE_RUN_LENGTH_ENCODER_ASSERT_SVH

// Same-cycle implication, off during reset.
`define BRLE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("brle assertion failed");

// Next-cycle implication, off during reset.
`define BRLE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("brle assertion failed");

`endif

[hw/rtl/brle_pkg.sv]
package brle_pkg;

  localparam int unsigned SIZE_WIDTH_DEFAULT = 32;
  localparam logic [7:0]  MAX_RUN            = 8'd255;
  localparam logic [31:0] LIMIT_RESET        = 32'd16777216;

  // APB register map (byte addresses)
  localparam int unsigned ADDR_WIDTH         = 3;
  localparam logic [ADDR_WIDTH-1:0] REG_OUTPUT_LIMIT = 3'd0;

  typedef struct packed {
    logic        packet_valid;
    logic [7:0]  run_length;
    logic [7:0]  symbol;
    logic        is_final;
    logic        overflow;
    logic [31:0] size_bytes;
  } result_t;

endpackage

[hw/rtl/byte_run_length_encoder.sv]
// Bytes wait in the input register; their results pass through the result queue to m_*.
// Throughput: one byte per cycle; a byte may give up to two results, which drain
// one per cycle through a four-entry result queue, so a pair-heavy burst can stall input.
// Reset (rst, synchronous, active high): run state, counters and queue cleared,
// output_limit returns to 16777216.
module byte_run_length_encoder #(
  parameter int unsigned SIZE_WIDTH = brle_pkg::SIZE_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [7:0] run_length, [15:8] symbol, [47:16] size_bytes
  output logic        m_tlast,   // is_final
  output logic [1:0]  m_tuser,   // [0] packet_valid, [1] overflow
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [brle_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // compare width: wide enough for either counter or the 32-bit limit, plus carry
  localparam int unsigned CW = ((SIZE_WIDTH > 32) ? SIZE_WIDTH : 32) + 1;
  localparam int unsigned QD = 4;
  localparam int unsigned QPW = $clog2(QD);
  localparam int unsigned QCW = $clog2(QD + 1);

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [31:0] output_limit;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr == brle_pkg::REG_OUTPUT_LIMIT);
  assign prdata = (paddr == brle_pkg::REG_OUTPUT_LIMIT) ? output_limit : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_limit <= brle_pkg::LIMIT_RESET;
    end else if (cfg_wr) begin
      output_limit <= pwdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic       stg_valid;
  logic [7:0] stg_byte;
  logic       stg_last;
  logic       fire;       // stage item is processed this cycle

  logic [QCW-1:0] q_count;

  // stage only proceeds with room for two results in the queue
  assign fire     = stg_valid && (q_count <= QCW'(QD - 2));
  assign s_tready = !stg_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (s_tready) begin
      stg_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      stg_byte <= s_tdata;
      stg_last <= s_tlast;
    end
  end

  // ---------------------------------------------------------------------------
  // Run state
  // ---------------------------------------------------------------------------
  logic [7:0]            run_symbol;
  logic [7:0]            run_len;      // 0 means no open run
  logic [SIZE_WIDTH-1:0] bytes_written;
  logic [SIZE_WIDTH-1:0] bytes_read;
  logic                  aborted;

  // ---------------------------------------------------------------------------
  // Encode logic
  // First close: the open run ends because the byte differs or the run is full.
  // Second close: end of stream. Each close first checks the output limit.
  // ---------------------------------------------------------------------------
  logic [CW-1:0]         limit_ext;
  logic [CW-1:0]         wr_plus2;
  logic                  close_a, ovf_a, emit_a, open_a;
  logic [SIZE_WIDTH-1:0] bw_a;
  logic [7:0]            cnt_base, cnt_b, sym_b;
  logic [CW-1:0]         wr_b_plus2;
  logic                  ovf_b, emit_b, ab_all, report;
  logic [SIZE_WIDTH-1:0] br_inc;
  logic [31:0]           size_b, size_r;
  brle_pkg::result_t     res_a, res_b;

  always_comb begin
    limit_ext  = CW'(output_limit);
    wr_plus2   = CW'(bytes_written) + CW'(2);
    close_a    = (run_len != 8'd0)
                 && ((stg_byte != run_symbol) || (run_len == brle_pkg::MAX_RUN));
    ovf_a      = !aborted && close_a && (wr_plus2 >= limit_ext);
    emit_a     = !aborted && close_a && !ovf_a;
    bw_a       = emit_a ? SIZE_WIDTH'(wr_plus2) : bytes_written;
    open_a     = !aborted && !ovf_a;

    cnt_base   = close_a ? 8'd0 : run_len;
    sym_b      = (cnt_base == 8'd0) ? stg_byte : run_symbol;
    cnt_b      = (cnt_base == 8'd0) ? 8'd1 : cnt_base + 8'd1;

    wr_b_plus2 = CW'(bw_a) + CW'(2);
    ovf_b      = open_a && stg_last && (wr_b_plus2 >= limit_ext);
    emit_b     = open_a && stg_last && !ovf_b;
    ab_all     = aborted || ovf_a || ovf_b;
    report     = stg_last && ab_all;

    br_inc     = bytes_read + SIZE_WIDTH'(1);
    // sizes wrap at SIZE_WIDTH, then show as 32 bits
    size_b     = 32'(CW'(SIZE_WIDTH'(wr_b_plus2)));
    size_r     = 32'(CW'(br_inc));

    res_a.packet_valid = 1'b1;
    res_a.run_length   = run_len;
    res_a.symbol       = run_symbol;
    res_a.is_final     = 1'b0;
    res_a.overflow     = 1'b0;
    res_a.size_bytes   = 32'd0;

    if (emit_b) begin
      res_b.packet_valid = 1'b1;
      res_b.run_length   = cnt_b;
      res_b.symbol       = sym_b;
      res_b.is_final     = 1'b1;
      res_b.overflow     = 1'b0;
      res_b.size_bytes   = size_b;
    end else begin
      // overflow report
      res_b.packet_valid = 1'b0;
      res_b.run_length   = 8'd0;
      res_b.symbol       = 8'd0;
      res_b.is_final     = 1'b1;
      res_b.overflow     = 1'b1;
      res_b.size_bytes   = size_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_symbol    <= 8'd0;
      run_len       <= 8'd0;
      bytes_written <= '0;
      bytes_read    <= '0;
      aborted       <= 1'b0;
    end else if (fire) begin
      if (stg_last) begin
        // stream done: back to the reset state
        run_symbol    <= 8'd0;
        run_len       <= 8'd0;
        bytes_written <= '0;
        bytes_read    <= '0;
        aborted       <= 1'b0;
      end else begin
        run_symbol    <= open_a ? sym_b : run_symbol;
        run_len       <= open_a ? cnt_b : 8'd0;
        bytes_written <= bw_a;
        bytes_read    <= br_inc;
        aborted       <= ab_all;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue: up to two writes, one read per cycle
  // ---------------------------------------------------------------------------
  brle_pkg::result_t q_mem [QD];
  logic [QPW-1:0]    wr_ptr, rd_ptr;
  logic              push_a, push_b, pop;
  logic [1:0]        push_cnt;
  brle_pkg::result_t head;

  assign push_a   = fire && emit_a;
  assign push_b   = fire && (emit_b || report);
  assign push_cnt = {1'b0, push_a} + {1'b0, push_b};
  assign pop      = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (push_a) begin
      q_mem[wr_ptr] <= res_a;
    end
    if (push_b) begin
      q_mem[push_a ? wr_ptr + QPW'(1) : wr_ptr] <= res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      wr_ptr  <= wr_ptr + QPW'(push_cnt);
      rd_ptr  <= rd_ptr + QPW'(pop);
      q_count <= q_count + QCW'(push_cnt) - QCW'(pop);
    end
  end

  assign head     = q_mem[rd_ptr];
  assign m_tvalid = (q_count != '0);
  assign m_tdata  = {head.size_bytes, head.symbol, head.run_length};
  assign m_tlast  = head.is_final;
  assign m_tuser  = {head.overflow, head.packet_valid};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`include "byte_run_length_encoder_assert.svh"

  `BRLE_ASSERT_IMPL(a_queue_bound, 1'b1, q_count <= QCW'(QD))
  `BRLE_ASSERT_NEXT(a_stream_clear, fire && stg_last, run_len == 8'd0 && bytes_written == '0 && bytes_read == '0 && !aborted)
  `BRLE_ASSERT_IMPL(a_overflow_final, m_tvalid && m_tuser[1], m_tlast && !m_tuser[0])

endmodule

[tb/sv/tb_byte_run_length_encoder.sv]
`timescale 1ns / 100ps

module tb_byte_run_length_encoder;

  // Generous ceiling: ~2000 bytes, each at worst a gap, two results and stalls,
  // plus the register writes between streams, taken several times over.
  localparam int unsigned CYCLE_LIMIT = 200000;
  // Address with no register behind it; writes there must be ignored.
  localparam logic [brle_pkg::ADDR_WIDTH-1:0] UNMAPPED_ADDR = 3'd4;
  // Cycles allowed after the last pair, with margin, before the block counts as quiet.
  localparam int unsigned SETTLE_CYCLES = 4;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tlast;
  logic [1:0]  m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [brle_pkg::ADDR_WIDTH-1:0] paddr = '0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  byte_run_length_encoder uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),   // [7:0] data_byte
    .s_tlast (s_tlast),   // last_byte
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),   // [7:0] run_length, [15:8] symbol, [47:16] size_bytes
    .m_tlast (m_tlast),   // is_final
    .m_tuser (m_tuser),   // [0] packet_valid, [1] overflow
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Encoder state as the block should hold it
  // ---------------------------------------------------------------------------
  logic [31:0] out_limit;
  logic [7:0]  run_sym;
  logic [7:0]  run_cnt;      // 0 means no open run
  logic [31:0] wr_bytes;     // compressed bytes written so far
  logic [31:0] rd_bytes;     // source bytes of the current stream
  logic        dropping;     // stream abandoned, bytes only counted

  brle_pkg::result_t pairs_due[$]; // results still owed by the block, oldest first

  int unsigned fail_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;
  logic        idle_on = 1'b0;

  task automatic clear_runs();
    run_sym  = 8'h00;
    run_cnt  = 8'h00;
    wr_bytes = 32'h0;
    rd_bytes = 32'h0;
    dropping = 1'b0;
  endtask

  // Close the open run: either a pair goes out or the limit is hit and the
  // stream is abandoned. The run is gone in both cases.
  task automatic emit_pair(input logic fin);
    brle_pkg::result_t r;
    if ({1'b0, wr_bytes} + 33'd2 >= {1'b0, out_limit}) begin
      dropping = 1'b1;
    end else begin
      wr_bytes       = wr_bytes + 32'd2;
      r.packet_valid = 1'b1;
      r.run_length   = run_cnt;
      r.symbol       = run_sym;
      r.is_final     = fin;
      r.overflow     = 1'b0;
      r.size_bytes   = fin ? wr_bytes : 32'h0;
      pairs_due.push_back(r);
    end
    run_cnt = 8'h00;
  endtask

  // Work out the results of one accepted source byte.
  task automatic encode_byte(input logic [7:0] b, input logic last);
    brle_pkg::result_t r;
    rd_bytes = rd_bytes + 32'd1;
    if (!dropping) begin
      // symbol change or full run closes the open run first
      if (run_cnt != 0 && (b != run_sym || run_cnt >= brle_pkg::MAX_RUN))
        emit_pair(1'b0);
      if (!dropping) begin
        if (run_cnt == 0) begin
          run_sym = b;
          run_cnt = 8'd1;
        end else begin
          run_cnt = run_cnt + 8'd1;
        end
        if (last)
          emit_pair(1'b1);
      end
    end
    if (last) begin
      // abandoned stream: one report carrying the full source count
      if (dropping) begin
        r.packet_valid = 1'b0;
        r.run_length   = 8'h00;
        r.symbol       = 8'h00;
        r.is_final     = 1'b1;
        r.overflow     = 1'b1;
        r.size_bytes   = rd_bytes;
        pairs_due.push_back(r);
      end
      clear_runs();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Source side
  // ---------------------------------------------------------------------------
  // One byte: optional idle gap with tvalid low, then hold tvalid until the transfer happens.
  // tvalid stays high on return so back-to-back bytes need no second NBA.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_on && $urandom_range(0, 99) < 8) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    encode_byte(b, last);
    bytes_sent++;
  endtask

  // Stop the source and let every owed result drain before touching registers.
  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    while (pairs_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Register port: setup cycle then access cycle, pready is always high
  // ---------------------------------------------------------------------------
  task automatic apb_access(input logic wr, input logic [brle_pkg::ADDR_WIDTH-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    // idle between accesses, with psel low
    @(posedge clk);
  endtask

  task automatic check_limit_reg();
    logic [31:0] rd;
    apb_access(1'b0, brle_pkg::REG_OUTPUT_LIMIT, 32'h0, rd);
    if (rd !== out_limit) begin
      $display("%0t: output_limit read back expected %0h, got %0h", $time, out_limit, rd);
      fail_count++;
    end
  endtask

  task automatic set_limit(input logic [31:0] v);
    logic [31:0] rd;
    wait_quiet();
    apb_access(1'b1, brle_pkg::REG_OUTPUT_LIMIT, v, rd);
    out_limit = v;
    check_limit_reg();
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------
  always @(posedge clk)
    m_tready <= !idle_on || ($urandom_range(0, 99) >= 8);

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    brle_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pairs_due.size() == 0) begin
        $display("%0t: result with none owed, expected nothing, got %0h/%0h/%0b/%0b",
                 $time, m_tdata, m_tuser, m_tlast, m_tvalid);
        fail_count++;
      end else begin
        want = pairs_due.pop_front();
        check_field("packet_valid", 32'(want.packet_valid), 32'(m_tuser[0]));
        check_field("run_length", 32'(want.run_length), 32'(m_tdata[7:0]));
        check_field("symbol", 32'(want.symbol), 32'(m_tdata[15:8]));
        check_field("is_final", 32'(want.is_final), 32'(m_tlast));
        check_field("overflow", 32'(want.overflow), 32'(m_tuser[1]));
        check_field("size_bytes", want.size_bytes, m_tdata[47:16]);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Single-byte stream, extreme bytes, symbol changes, under the reset limit.
  task automatic test_basic_pairs();
    check_limit_reg();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h5A, 1'b1);
  endtask

  // Limits of 2 or less abort on the first pair; a limit of 4 lets one pair
  // through, including the case where the abort lands on the last byte.
  task automatic test_small_limit();
    set_limit(32'd0);
    send_byte(8'h3C, 1'b1);
    set_limit(32'd2);
    send_byte(8'h01, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b1);
    set_limit(32'd4);
    send_byte(8'h07, 1'b0);
    send_byte(8'h08, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b1);
    set_limit(32'hFFFF_FFFF);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
  endtask

  // A write to an address with no register must leave output_limit alone.
  task automatic test_unmapped_write();
    logic [31:0] rd;
    set_limit(32'd6);
    apb_access(1'b1, UNMAPPED_ADDR, $urandom, rd);
    check_limit_reg();
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b1);
  endtask

  // One random stream: mostly runs (short, medium and past the 255 cap),
  // sometimes plain noise bytes.
  task automatic send_random_stream();
    int unsigned n_runs;
    int unsigned len;
    int unsigned p;
    logic [7:0]  sym;
    logic        noise;
    noise  = ($urandom_range(0, 99) < 20);
    n_runs = noise ? $urandom_range(1, 24) : $urandom_range(1, 8);
    sym    = 8'($urandom_range(0, 255));
    for (int unsigned r = 0; r < n_runs; r++) begin
      if (noise) begin
        len = 1;
        sym = 8'($urandom_range(0, 255));
      end else begin
        p = $urandom_range(0, 99);
        if (p < 60)      len = $urandom_range(1, 4);
        else if (p < 92) len = $urandom_range(5, 40);
        else             len = $urandom_range(240, 520);
        // a repeated symbol merges with the previous run
        if ($urandom_range(0, 99) >= 25)
          sym = 8'($urandom_range(0, 255));
      end
      for (int unsigned i = 0; i < len; i++)
        send_byte(sym, (r == n_runs - 1) && (i == len - 1));
    end
  endtask

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(0, 4))
      0:       return 32'hFFFF_FFFF;
      1:       return brle_pkg::LIMIT_RESET;
      2:       return $urandom_range(0, 8);
      3:       return $urandom_range(9, 80);
      default: return $urandom;
    endcase
  endfunction

  // Long stretch with both sides always ready.
  task automatic test_steady_flow();
    int unsigned stop_at;
    idle_on = 1'b0;
    set_limit(brle_pkg::LIMIT_RESET);
    stop_at = bytes_sent + 400;
    while (bytes_sent < stop_at)
      send_random_stream();
  endtask

  // Random gaps and stalls, limit changed every few streams.
  task automatic test_random_streams();
    int unsigned stop_at;
    int unsigned streams;
    idle_on = 1'b1;
    stop_at = bytes_sent + 1400;
    streams = 0;
    while (bytes_sent < stop_at) begin
      if (streams % 6 == 0)
        set_limit(pick_limit());
      send_random_stream();
      streams++;
    end
  endtask

  initial begin
    out_limit = brle_pkg::LIMIT_RESET;
    clear_runs();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_pairs();
    test_small_limit();
    test_unmapped_write();
    test_steady_flow();
    test_random_streams();

    wait_quiet();
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[byte_run_length_encoder.f]
+incdir+hw/rtl
hw/rtl/brle_pkg.sv
hw/rtl/byte_run_length_encoder.sv
tb/sv/tb_byte_run_length_encoder.sv
